### hw/rtl/uart_pkg.sv
package uart_pkg;

	localparam int unsigned FRAME_BITS = 10;
	localparam int unsigned DATA_BITS  = 8;

	typedef logic [9:0] presc_cnt_t;
	typedef logic [7:0] period_cnt_t;
	typedef logic [3:0] bit_cnt_t;
	typedef logic [0:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PRESCALE = 1'b0;
	localparam cfg_idx_t CFG_COMPARE  = 1'b1;

	typedef enum logic [2:0] {
		PRESC_DIV1    = 3'd0,
		PRESC_DIV8    = 3'd1,
		PRESC_DIV64   = 3'd2,
		PRESC_DIV256  = 3'd3,
		PRESC_DIV1024 = 3'd4
	} presc_code_t;

	typedef enum logic [1:0] {
		RX_IDLE = 2'd0,
		RX_HALF = 2'd1,
		RX_DATA = 2'd2
	} rx_phase_t;

	typedef struct packed {
		logic       send_request;
		logic [7:0] send_byte;
		logic       rx_level;
	} in_item_t;

	typedef struct packed {
		logic       tx_level;
		logic       tx_busy;
		logic       rx_busy;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} out_item_t;

	typedef struct packed {
		logic [2:0] prescale_code;
		logic [7:0] compare_value;
	} uart_cfg_t;

	typedef struct packed {
		logic level;
		logic busy;
	} tx_status_t;

	typedef struct packed {
		logic       busy;
		logic       valid;
		logic [7:0] data;
	} rx_status_t;

	function automatic presc_cnt_t div_minus_one(input logic [2:0] code);
		presc_cnt_t r;
		unique case (code)
			PRESC_DIV1:   r = 10'd0;
			PRESC_DIV8:   r = 10'd7;
			PRESC_DIV64:  r = 10'd63;
			PRESC_DIV256: r = 10'd255;
			default:      r = 10'd1023;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/uart_tx.sv
module uart_tx (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 send_request,
	input  logic [7:0]           send_byte,
	input  uart_pkg::uart_cfg_t  cfg,
	output uart_pkg::tx_status_t status
);

	uart_pkg::presc_cnt_t  presc_q, presc_d;
	uart_pkg::period_cnt_t period_q, period_d;
	logic [9:0]            frame_q, frame_d;
	uart_pkg::bit_cnt_t    left_q, left_d;

	uart_pkg::presc_cnt_t  presc_c;
	uart_pkg::period_cnt_t period_c;
	logic [9:0]            frame_c;
	uart_pkg::bit_cnt_t    left_c;
	logic                  start;
	logic                  busy;
	logic                  tick;
	logic                  hit;

	always_comb begin
		start    = (left_q == '0) && send_request;
		presc_c  = start ? '0 : presc_q;
		period_c = start ? '0 : period_q;
		frame_c  = start ? {1'b1, send_byte, 1'b0} : frame_q;
		left_c   = start ? 4'(uart_pkg::FRAME_BITS) : left_q;
		busy     = (left_c != '0);
		tick     = (presc_c == uart_pkg::div_minus_one(cfg.prescale_code));
		hit      = (period_c == cfg.compare_value);

		presc_d  = presc_c;
		period_d = period_c;
		frame_d  = frame_c;
		left_d   = left_c;
		if (busy) begin
			presc_d = tick ? '0 : presc_c + 10'd1;
			if (tick) begin
				period_d = hit ? '0 : period_c + 8'd1;
				if (hit) begin
					frame_d = {1'b1, frame_c[9:1]};
					left_d  = left_c - 4'd1;
					if (left_d == '0)
						frame_d = '1;
				end
			end
		end

		status.busy  = busy;
		status.level = busy ? frame_c[0] : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q  <= '0;
			period_q <= '0;
			frame_q  <= '1;
			left_q   <= '0;
		end else if (step) begin
			presc_q  <= presc_d;
			period_q <= period_d;
			frame_q  <= frame_d;
			left_q   <= left_d;
		end
	end

endmodule

### hw/rtl/uart_rx.sv
module uart_rx (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 rx_level,
	input  uart_pkg::uart_cfg_t  cfg,
	output uart_pkg::rx_status_t status
);

	uart_pkg::rx_phase_t   phase_q, phase_d, phase_c;
	uart_pkg::presc_cnt_t  presc_q, presc_d, presc_c;
	uart_pkg::period_cnt_t period_q, period_d, period_c;
	logic [7:0]            shift_q, shift_d;
	uart_pkg::bit_cnt_t    bits_q, bits_d;
	logic                  prev_q;

	logic                  tick;
	logic                  hit_half;
	logic                  hit_full;

	always_comb begin
		unique case (phase_q)
			uart_pkg::RX_HALF: phase_c = uart_pkg::RX_HALF;
			uart_pkg::RX_DATA: phase_c = uart_pkg::RX_DATA;
			default:           phase_c = uart_pkg::RX_IDLE;
		endcase
		presc_c  = presc_q;
		period_c = period_q;
		if (phase_c == uart_pkg::RX_IDLE && prev_q && !rx_level) begin
			phase_c  = uart_pkg::RX_HALF;
			presc_c  = '0;
			period_c = '0;
		end

		tick     = (presc_c == uart_pkg::div_minus_one(cfg.prescale_code));
		hit_half = (period_c == {1'b0, cfg.compare_value[7:1]});
		hit_full = (period_c == cfg.compare_value);

		phase_d  = phase_c;
		presc_d  = presc_c;
		period_d = period_c;
		shift_d  = shift_q;
		bits_d   = bits_q;

		status.busy  = (phase_c != uart_pkg::RX_IDLE);
		status.valid = 1'b0;
		status.data  = '0;

		unique case (phase_c)
			uart_pkg::RX_HALF: begin
				presc_d = tick ? '0 : presc_c + 10'd1;
				if (tick) begin
					period_d = hit_half ? '0 : period_c + 8'd1;
					if (hit_half) begin
						phase_d = uart_pkg::RX_DATA;
						bits_d  = '0;
						shift_d = '0;
					end
				end
			end
			uart_pkg::RX_DATA: begin
				presc_d = tick ? '0 : presc_c + 10'd1;
				if (tick) begin
					period_d = hit_full ? '0 : period_c + 8'd1;
					if (hit_full) begin
						shift_d = {rx_level, shift_q[7:1]};
						bits_d  = bits_q + 4'd1;
						if (bits_d >= 4'(uart_pkg::DATA_BITS)) begin
							status.valid = 1'b1;
							status.data  = shift_d;
							bits_d       = '0;
							phase_d      = uart_pkg::RX_IDLE;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= uart_pkg::RX_IDLE;
			presc_q  <= '0;
			period_q <= '0;
			shift_q  <= '0;
			bits_q   <= '0;
			prev_q   <= 1'b1;
		end else if (step) begin
			phase_q  <= phase_d;
			presc_q  <= presc_d;
			period_q <= period_d;
			shift_q  <= shift_d;
			bits_q   <= bits_d;
			prev_q   <= rx_level;
		end
	end

endmodule

### hw/rtl/uart_8n1_transceiver.sv
// UART 8N1 transceiver, one item per system clock cycle of line activity.
// Input channel (in_valid/in_stall, in_item): send request, send byte and the
// sampled receive line level. Output channel (out_valid/out_stall, out_item):
// transmit line level, busy flags, and a received byte with a one-item strobe.
// Every input item yields exactly one output item.
// An accepted item sits in the input register; when it advances, the transmit
// and receive timers update from it and its result is captured in the result
// register, which drives out_valid.
// Throughput: one item per cycle while the output is not stalled, set by the
// combinational timer update between input and result registers.
// If the receiver stalls, the result register holds its item, the input
// register keeps one more, and in_stall rises only when both are full.
// Configuration (cfg_write, cfg_index, cfg_data) is registered and applies to
// items processed after the write; index 0 is the prescale code, index 1 the compare value.
// Reset: both lines idle, timers cleared, prescale code 1, compare value 207.
module uart_8n1_transceiver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  uart_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output uart_pkg::out_item_t out_item,
	input  logic                cfg_write,
	input  uart_pkg::cfg_idx_t  cfg_index,
	input  logic [7:0]          cfg_data
);

	uart_pkg::uart_cfg_t  cfg_q;
	logic                 valid_s1;
	uart_pkg::in_item_t   item_s1;
	logic                 out_valid_q;
	uart_pkg::out_item_t  out_item_q;
	logic                 advance;
	logic                 in_accept;
	uart_pkg::tx_status_t tx_status;
	uart_pkg::rx_status_t rx_status;

	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prescale_code <= 3'd1;
			cfg_q.compare_value <= 8'd207;
		end else if (cfg_write) begin
			unique case (cfg_index)
				uart_pkg::CFG_PRESCALE: cfg_q.prescale_code <= cfg_data[2:0];
				uart_pkg::CFG_COMPARE:  cfg_q.compare_value <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			item_s1 <= in_item;
	end

	uart_tx u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.send_request (item_s1.send_request),
		.send_byte    (item_s1.send_byte),
		.cfg          (cfg_q),
		.status       (tx_status)
	);

	uart_rx u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.rx_level (item_s1.rx_level),
		.cfg      (cfg_q),
		.status   (rx_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.tx_level <= tx_status.level;
			out_item_q.tx_busy  <= tx_status.busy;
			out_item_q.rx_busy  <= rx_status.busy;
			out_item_q.rx_valid <= rx_status.valid;
			out_item_q.rx_byte  <= rx_status.data;
		end
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item did not reach the result register");

	a_rx_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_item_q.rx_valid || out_item_q.rx_busy))
		else $error("received byte strobe outside a reception");

	a_tx_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.tx_busy || out_item_q.tx_level))
		else $error("transmit line low while idle");

	a_rx_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.rx_valid || out_item_q.rx_byte == 8'd0))
		else $error("received byte nonzero without strobe");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] PRESC_SPARE = 3'd7;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	uart_pkg::in_item_t  in_item = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	uart_pkg::out_item_t out_item;
	logic                cfg_write = 1'b0;
	uart_pkg::cfg_idx_t  cfg_index = uart_pkg::CFG_PRESCALE;
	logic [7:0]          cfg_data = 8'd0;

	uart_8n1_transceiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// line state mirrored cycle by cycle
	logic [2:0]            cfg_presc = uart_pkg::PRESC_DIV8;
	logic [7:0]            cfg_cmp = 8'd207;
	uart_pkg::presc_cnt_t  tx_tick_cnt = '0;
	uart_pkg::period_cnt_t tx_bit_cnt = '0;
	logic [9:0]            tx_shift_reg = '1;
	uart_pkg::bit_cnt_t    tx_remaining = '0;
	uart_pkg::presc_cnt_t  rx_tick_cnt = '0;
	uart_pkg::period_cnt_t rx_bit_cnt = '0;
	uart_pkg::rx_phase_t   rx_state = uart_pkg::RX_IDLE;
	logic [7:0]            rx_data_reg = '0;
	uart_pkg::bit_cnt_t    rx_sampled = '0;
	logic                  rx_last_level = 1'b1;

	uart_pkg::in_item_t  stim_q[$];
	uart_pkg::out_item_t line_out_q[$];
	uart_pkg::out_item_t oldest;

	int items_queued = 0;
	int items_sent = 0;
	int results_seen = 0;
	int mismatch_cnt = 0;
	int tx_frames = 0;
	int rx_bytes = 0;
	int settings_done = 0;
	int req_odds = 0;
	int send_gap = 0;
	int recv_wait = 0;
	int hold_left = 0;
	int next_hold_at = 300;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;

	function automatic uart_pkg::presc_cnt_t tick_limit(logic [2:0] code);
		case (code)
			uart_pkg::PRESC_DIV1:   return 10'd0;
			uart_pkg::PRESC_DIV8:   return 10'd7;
			uart_pkg::PRESC_DIV64:  return 10'd63;
			uart_pkg::PRESC_DIV256: return 10'd255;
			default:                return 10'd1023;
		endcase
	endfunction

	function automatic uart_pkg::out_item_t step_uart(uart_pkg::in_item_t it);
		uart_pkg::out_item_t  r;
		uart_pkg::presc_cnt_t lim;
		logic                 tick;
		r = '0;
		lim = tick_limit(cfg_presc);

		if (tx_remaining == 0 && it.send_request) begin
			tx_shift_reg = {1'b1, it.send_byte, 1'b0};
			tx_remaining = uart_pkg::bit_cnt_t'(uart_pkg::FRAME_BITS);
			tx_tick_cnt = '0;
			tx_bit_cnt = '0;
			tx_frames++;
		end
		r.tx_busy = (tx_remaining != 0);
		r.tx_level = r.tx_busy ? tx_shift_reg[0] : 1'b1;
		if (r.tx_busy) begin
			tick = (tx_tick_cnt == lim);
			tx_tick_cnt = tick ? '0 : tx_tick_cnt + 1'b1;
			if (tick) begin
				tick = (tx_bit_cnt == cfg_cmp);
				tx_bit_cnt = tick ? '0 : tx_bit_cnt + 1'b1;
				if (tick) begin
					tx_shift_reg = {1'b1, tx_shift_reg[9:1]};
					tx_remaining = tx_remaining - 1'b1;
					if (tx_remaining == 0)
						tx_shift_reg = '1;
				end
			end
		end

		if (rx_state == uart_pkg::RX_IDLE && rx_last_level && !it.rx_level) begin
			rx_state = uart_pkg::RX_HALF;
			rx_tick_cnt = '0;
			rx_bit_cnt = '0;
		end
		r.rx_busy = (rx_state != uart_pkg::RX_IDLE);
		if (rx_state == uart_pkg::RX_HALF) begin
			tick = (rx_tick_cnt == lim);
			rx_tick_cnt = tick ? '0 : rx_tick_cnt + 1'b1;
			if (tick) begin
				tick = (rx_bit_cnt == (cfg_cmp >> 1));
				rx_bit_cnt = tick ? '0 : rx_bit_cnt + 1'b1;
				if (tick) begin
					rx_state = uart_pkg::RX_DATA;
					rx_sampled = '0;
					rx_data_reg = '0;
				end
			end
		end else if (rx_state == uart_pkg::RX_DATA) begin
			tick = (rx_tick_cnt == lim);
			rx_tick_cnt = tick ? '0 : rx_tick_cnt + 1'b1;
			if (tick) begin
				tick = (rx_bit_cnt == cfg_cmp);
				rx_bit_cnt = tick ? '0 : rx_bit_cnt + 1'b1;
				if (tick) begin
					rx_data_reg = {it.rx_level, rx_data_reg[7:1]};
					rx_sampled = rx_sampled + 1'b1;
					if (rx_sampled >= uart_pkg::DATA_BITS) begin
						r.rx_valid = 1'b1;
						r.rx_byte = rx_data_reg;
						rx_sampled = '0;
						rx_state = uart_pkg::RX_IDLE;
						rx_bytes++;
					end
				end
			end
		end
		rx_last_level = it.rx_level;
		return r;
	endfunction

	function automatic void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("mismatch at result %0d: %s expected %0h, got %0h",
					results_seen, what, want, got);
		end
	endfunction

	function automatic void push_item(logic req, logic [7:0] data, logic level);
		uart_pkg::in_item_t it;
		it.send_request = req;
		it.send_byte = data;
		it.rx_level = level;
		stim_q.push_back(it);
		items_queued++;
	endfunction

	function automatic void push_level(int n, logic level);
		repeat (n)
			push_item(req_odds != 0 && $urandom_range(1, req_odds) == 1,
				8'($urandom_range(0, 255)), level);
	endfunction

	function automatic void push_rx_frame(logic [7:0] data, int bit_len);
		push_level(bit_len, 1'b0);
		for (int i = 0; i < 8; i++)
			push_level(bit_len, data[i]);
		push_level(bit_len, 1'b1);
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (stim_q.size() != 0 || in_valid || line_out_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic apply_setting(logic [2:0] code, logic [7:0] cmp);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= uart_pkg::CFG_PRESCALE;
		cfg_data <= {5'd0, code};
		cfg_presc = code;
		@(posedge clk);
		cfg_index <= uart_pkg::CFG_COMPARE;
		cfg_data <= cmp;
		cfg_cmp = cmp;
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_done++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				line_out_q.push_back(step_uart(in_item));
				items_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					in_item <= stim_q.pop_front();
					in_valid <= 1'b1;
					send_gap <= send_quiet ? 0 : $urandom_range(0, 5);
					if ($urandom_range(0, 39) == 0)
						send_quiet <= !send_quiet;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (line_out_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result %0d: %p", results_seen, out_item);
				end else begin
					oldest = line_out_q.pop_front();
					check_field("tx_level", oldest.tx_level, out_item.tx_level);
					check_field("tx_busy", oldest.tx_busy, out_item.tx_busy);
					check_field("rx_busy", oldest.rx_busy, out_item.rx_busy);
					check_field("rx_valid", oldest.rx_valid, out_item.rx_valid);
					check_field("rx_byte", oldest.rx_byte, out_item.rx_byte);
				end
				results_seen <= results_seen + 1;
				recv_wait = recv_quiet ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 39) == 0)
					recv_quiet = !recv_quiet;
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			out_stall <= (hold_left != 0) || (recv_wait != 0);
		end
	end

	// long hold on the output so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			next_hold_at <= 300;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (results_seen >= next_hold_at && stim_q.size() > 10) begin
			hold_left <= 80;
			next_hold_at <= next_hold_at + 3000;
		end
	end

	initial begin
		int         start_count;
		int         per;
		logic [2:0] code;
		logic [7:0] cmp;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// idle line under the reset setting
		repeat (3) push_item(1'b0, 8'h00, 1'b1);

		apply_setting(uart_pkg::PRESC_DIV1, 8'd0);
		push_item(1'b1, 8'h00, 1'b1);
		req_odds = 1;
		push_rx_frame(8'h55, 1);
		push_item(1'b1, 8'hFF, 1'b1);
		req_odds = 3;
		push_rx_frame(8'h00, 1);
		push_level(1, 1'b0);
		push_level(3, 1'b1);

		start_count = items_queued;
		while (items_queued - start_count < 150) begin
			code = ($urandom_range(0, 3) == 0) ? uart_pkg::PRESC_DIV8 : uart_pkg::PRESC_DIV1;
			if (code == uart_pkg::PRESC_DIV1)
				cmp = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(4, 15))
					: 8'($urandom_range(0, 3));
			else
				cmp = 8'($urandom_range(0, 1));
			apply_setting(code, cmp);
			per = (cmp + 1) * ((code == uart_pkg::PRESC_DIV1) ? 1 : 8);
			req_odds = $urandom_range(1, 12);
			repeat ($urandom_range(2, 4)) begin
				if ($urandom_range(0, 4) != 0)
					push_rx_frame(8'($urandom_range(0, 255)), per);
				else
					repeat ($urandom_range(1, 2 * per)) push_level(1, 1'($urandom_range(0, 1)));
				push_level($urandom_range(0, 2 * per), 1'b1);
			end
		end

		// shrink the bit period while both sides are mid-frame
		apply_setting(uart_pkg::PRESC_DIV1, 8'd7);
		req_odds = 0;
		push_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
		push_level(20, 1'b0);
		apply_setting(uart_pkg::PRESC_DIV1, 8'd2);
		push_level(300, 1'b1);

		apply_setting(uart_pkg::PRESC_DIV1, 8'd255);
		push_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
		push_level(135, 1'b0);

		apply_setting(uart_pkg::PRESC_DIV64, 8'd0);
		push_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
		push_level(100, 1'b0);

		apply_setting(uart_pkg::PRESC_DIV256, 8'd0);
		push_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
		push_level(10, 1'b0);

		apply_setting(uart_pkg::PRESC_DIV1024, 8'd0);
		push_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
		push_level(10, 1'b0);

		apply_setting(PRESC_SPARE, 8'd0);
		push_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
		push_level(10, 1'b0);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("ran %0d cycles of line activity across %0d timer settings",
			items_sent, settings_done);
		$display("%0d frames sent, %0d bytes received, %0d mismatches",
			tx_frames, rx_bytes, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timed out with %0d results outstanding", line_out_q.size());
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
